// ----- rtl/core/cpts_pkg.sv -----
// ----------------------------------------------------------------------------
// cpts_pkg: shared types and constants
// Item, configuration and result types and the command, step and register
// codes used by the pan tracking block.
// ----------------------------------------------------------------------------
package cpts_pkg;

  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_BLOCK = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_FWD  = 2'd1;
  localparam logic [1:0] STEP_BWD  = 2'd2;

  localparam logic [2:0] REG_STEP_LIMIT   = 3'd0;
  localparam logic [2:0] REG_LOST_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_DEADBAND     = 3'd2;
  localparam logic [2:0] REG_DEG_PER_STEP = 3'd3;
  localparam logic [2:0] REG_GRACE        = 3'd4;

  localparam logic [6:0]  STEP_LIMIT_RST   = 7'd23;
  localparam logic [15:0] LOST_TIMEOUT_RST = 16'd50;
  localparam logic [9:0]  DEADBAND_RST     = 10'd240;
  localparam logic [7:0]  DEG_PER_STEP_RST = 8'd8;
  localparam logic [15:0] GRACE_RST        = 16'd1000;

  // Reciprocal of 319 scaled by 1200, in units of 2^-20, rounded up.
  localparam logic [21:0] ANGLE_RECIP = 22'd3944487;
  localparam int unsigned ANGLE_SHIFT = 20;
  localparam logic [10:0] ANGLE_OFFSET = 11'd600;
  localparam logic [8:0]  IMG_SPAN_COL = 9'd319;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] time_ms;
    logic [15:0] target;
    logic [15:0] signature;
    logic [8:0]  block_x;
    logic [7:0]  block_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        time_ms;
    logic [15:0]        target;
    logic [15:0]        signature;
    logic signed [10:0] angle_q4;
    logic [7:0]         block_y;
  } trk_item_t;

  typedef struct packed {
    logic [6:0]  step_limit;
    logic [15:0] lost_timeout_ms;
    logic [9:0]  deadband_q4;
    logic [7:0]  deg_per_step;
    logic [15:0] reacquire_grace_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         step;
    logic signed [7:0]  pan_position;
    logic signed [15:0] bearing_q4;
    logic [7:0]         ball_row;
    logic               visible;
  } out_item_t;

endpackage

// ----- rtl/core/cpts_if.sv -----
// ----------------------------------------------------------------------------
// cpts_in_if / cpts_out_if: item channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface cpts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] time_ms;
  logic [15:0] target;
  logic [15:0] signature;
  logic [8:0]  block_x;
  logic [7:0]  block_y;

  modport source (output valid, cmd, time_ms, target, signature, block_x, block_y,
                  input ready);
  modport sink (input valid, cmd, time_ms, target, signature, block_x, block_y,
                output ready);
endinterface

interface cpts_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         step;
  logic signed [7:0]  pan_position;
  logic signed [15:0] bearing_q4;
  logic [7:0]         ball_row;
  logic               visible;

  modport source (output valid, step, pan_position, bearing_q4, ball_row, visible,
                  input ready);
  modport sink (input valid, step, pan_position, bearing_q4, ball_row, visible,
                output ready);
endinterface

// ----- rtl/core/cpts_angle.sv -----
// ----------------------------------------------------------------------------
// cpts_angle: ball angle stage
// Converts the block column to a bearing in 1/16 degree, truncated toward
// zero and saturated to 11 bits, and registers it with the item.
// ----------------------------------------------------------------------------
module cpts_angle (
  input  logic                clk,
  input  logic                en,
  input  cpts_pkg::in_item_t  item_i,
  output cpts_pkg::trk_item_t item_o
);
  import cpts_pkg::*;

  logic [30:0]        prod;
  logic [10:0]        quot;
  logic               exact;
  logic signed [11:0] diff;
  logic signed [10:0] angle;
  trk_item_t          item_r;

  always_comb begin
    prod  = 31'(item_i.block_x) * 31'(ANGLE_RECIP);
    quot  = prod[ANGLE_SHIFT +: 11];
    // The quotient is exact only at the first and last image columns.
    exact = (item_i.block_x == 9'd0) || (item_i.block_x == IMG_SPAN_COL);
    diff  = $signed({1'b0, quot}) - $signed({1'b0, ANGLE_OFFSET});
    if ((quot < ANGLE_OFFSET) && !exact) begin
      diff = diff + 12'sd1;
    end
    if (diff > 12'sd1023) begin
      angle = 11'sd1023;
    end else begin
      angle = diff[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r.cmd       <= item_i.cmd;
      item_r.time_ms   <= item_i.time_ms;
      item_r.target    <= item_i.target;
      item_r.signature <= item_i.signature;
      item_r.angle_q4  <= angle;
      item_r.block_y   <= item_i.block_y;
    end
  end

  assign item_o = item_r;

endmodule

// ----- rtl/core/cpts_track.sv -----
// ----------------------------------------------------------------------------
// cpts_track: tracking state and result logic
// Holds the target, ball and pan state, applies one item per enabled cycle
// and forms the result from the updated state.
// ----------------------------------------------------------------------------
module cpts_track (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  cpts_pkg::trk_item_t item_i,
  input  cpts_pkg::cfg_t      cfg_i,
  output cpts_pkg::out_item_t res_o
);
  import cpts_pkg::*;

  logic [15:0]        target_r, target_nxt;
  logic signed [10:0] angle_r, angle_nxt;
  logic [7:0]         row_r, row_nxt;
  logic               found_r, found_nxt;
  logic               search_r, search_nxt;
  logic               fwd_r, fwd_nxt;
  logic signed [7:0]  pos_r, pos_nxt;
  logic [31:0]        last_r, last_nxt;

  logic signed [9:0]  lim;
  logic signed [9:0]  lim1;
  logic signed [9:0]  pos10;
  logic signed [9:0]  pos_abs;
  logic signed [11:0] angle_abs;
  logic [31:0]        elapsed;
  logic [31:0]        elapsed_nxt;
  logic [31:0]        timeout32;
  logic               do_move;
  logic               move_fwd;
  logic [1:0]         step;
  logic signed [17:0] scaled;
  logic signed [21:0] bearing;
  logic signed [15:0] bearing_sat;

  always_comb begin
    target_nxt = target_r;
    angle_nxt  = angle_r;
    row_nxt    = row_r;
    found_nxt  = found_r;
    search_nxt = search_r;
    fwd_nxt    = fwd_r;
    pos_nxt    = pos_r;
    last_nxt   = last_r;
    do_move    = 1'b0;
    move_fwd   = 1'b0;

    lim       = $signed({3'b000, cfg_i.step_limit});
    lim1      = lim - 10'sd1;
    pos10     = $signed({{2{pos_r[7]}}, pos_r});
    pos_abs   = (pos10 < 10'sd0) ? -pos10 : pos10;
    angle_abs = (angle_r < 11'sd0) ? -$signed({angle_r[10], angle_r})
                                   : $signed({angle_r[10], angle_r});
    timeout32 = {16'd0, cfg_i.lost_timeout_ms};
    elapsed   = item_i.time_ms - last_r;

    case (item_i.cmd)
      CMD_FRAME: begin
        if (item_i.target != target_r) begin
          target_nxt = item_i.target;
          last_nxt   = item_i.time_ms + {16'd0, cfg_i.reacquire_grace_ms};
        end
        if (pos10 > lim) begin
          pos_nxt = lim[7:0];
        end else if (pos10 < -lim) begin
          pos_nxt = 8'(-lim);
        end
      end
      CMD_BLOCK: begin
        if (item_i.signature == target_r) begin
          angle_nxt = item_i.angle_q4;
          row_nxt   = item_i.block_y;
          found_nxt = 1'b1;
          last_nxt  = item_i.time_ms;
        end
      end
      CMD_TICK: begin
        if (elapsed > timeout32) begin
          do_move = 1'b1;
          if (pos10 > lim1) begin
            search_nxt = 1'b1;
            fwd_nxt    = 1'b0;
            move_fwd   = 1'b0;
          end else if (pos10 < -lim1) begin
            search_nxt = 1'b1;
            fwd_nxt    = 1'b1;
            move_fwd   = 1'b1;
          end else if (!search_r) begin
            move_fwd = !(angle_r > 11'sd0);
          end else begin
            move_fwd = fwd_r;
          end
        end else if (found_r && !(pos_abs > lim1)) begin
          fwd_nxt    = 1'b1;
          search_nxt = 1'b0;
          found_nxt  = 1'b0;
          if (angle_abs >= $signed({2'b00, cfg_i.deadband_q4})) begin
            do_move  = 1'b1;
            move_fwd = !(angle_r > 11'sd0);
          end
        end
      end
      default: begin
      end
    endcase

    step = STEP_NONE;
    if (do_move) begin
      if (move_fwd) begin
        step = STEP_FWD;
        if (pos_r != 8'sd127) begin
          pos_nxt = pos_r + 8'sd1;
        end
      end else begin
        step = STEP_BWD;
        if (pos_r != -8'sd128) begin
          pos_nxt = pos_r - 8'sd1;
        end
      end
    end

    elapsed_nxt = item_i.time_ms - last_nxt;
    scaled      = $signed({pos_nxt[7], pos_nxt}) * $signed({1'b0, cfg_i.deg_per_step});
    bearing     = $signed({scaled, 4'b0000}) - 22'(angle_nxt);
    if (bearing > 22'sd32767) begin
      bearing_sat = 16'sd32767;
    end else if (bearing < -22'sd32768) begin
      bearing_sat = -16'sd32768;
    end else begin
      bearing_sat = bearing[15:0];
    end

    res_o.step         = step;
    res_o.pan_position = pos_nxt;
    res_o.bearing_q4   = bearing_sat;
    res_o.ball_row     = row_nxt;
    res_o.visible      = elapsed_nxt < timeout32;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      angle_r  <= '0;
      row_r    <= '0;
      found_r  <= 1'b0;
      search_r <= 1'b0;
      fwd_r    <= 1'b1;
      pos_r    <= '0;
      last_r   <= '0;
    end else if (en) begin
      target_r <= target_nxt;
      angle_r  <= angle_nxt;
      row_r    <= row_nxt;
      found_r  <= found_nxt;
      search_r <= search_nxt;
      fwd_r    <= fwd_nxt;
      pos_r    <= pos_nxt;
      last_r   <= last_nxt;
    end
  end

endmodule

// ----- rtl/core/camera_pan_track_search.sv -----
// Path: input register, ball angle register, then result register.
// Throughput: one item per cycle unless stalled; state update takes one a cycle.
// Each stage holds its item until the next stage has room, so a stalled
// result does not stop the input side until all three stages are full.
// Reset (rst_n low, synchronous) empties the pipeline, clears the tracking
// state, sets the sweep direction forward and loads register defaults.
// ----------------------------------------------------------------------------
// camera_pan_track_search: pan stepper tracking a colour-signature target
// Input register, ball angle stage, and tracking state with result register,
// plus the APB-style configuration registers.
// ----------------------------------------------------------------------------
module camera_pan_track_search (
  input  logic        clk,
  input  logic        rst_n,
  cpts_in_if.sink     in_ch,
  cpts_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import cpts_pkg::*;

  cfg_t      cfg_r;
  in_item_t  s1_item_r;
  logic      s1_v_r;
  logic      s2_v_r;
  logic      out_v_r;
  out_item_t out_item_r;
  trk_item_t s2_item;
  out_item_t res;
  logic      out_adv;
  logic      s2_rdy;
  logic      s2_go;
  logic      s1_rdy;
  logic      s1_go;
  logic      in_go;
  logic      cfg_wr;

  assign out_adv = !out_v_r || out_ch.ready;
  assign s2_go   = s2_v_r && out_adv;
  assign s2_rdy  = !s2_v_r || out_adv;
  assign s1_go   = s1_v_r && s2_rdy;
  assign s1_rdy  = !s1_v_r || s2_rdy;
  assign in_go   = in_ch.valid && s1_rdy;

  assign in_ch.ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_ch.valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_item_r.cmd       <= in_ch.cmd;
      s1_item_r.time_ms   <= in_ch.time_ms;
      s1_item_r.target    <= in_ch.target;
      s1_item_r.signature <= in_ch.signature;
      s1_item_r.block_x   <= in_ch.block_x;
      s1_item_r.block_y   <= in_ch.block_y;
    end
    if (s2_go) begin
      out_item_r <= res;
    end
  end

  cpts_angle u_angle (
    .clk    (clk),
    .en     (s1_go),
    .item_i (s1_item_r),
    .item_o (s2_item)
  );

  cpts_track u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (s2_go),
    .item_i (s2_item),
    .cfg_i  (cfg_r),
    .res_o  (res)
  );

  assign out_ch.valid        = out_v_r;
  assign out_ch.step         = out_item_r.step;
  assign out_ch.pan_position = out_item_r.pan_position;
  assign out_ch.bearing_q4   = out_item_r.bearing_q4;
  assign out_ch.ball_row     = out_item_r.ball_row;
  assign out_ch.visible      = out_item_r.visible;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_limit         <= STEP_LIMIT_RST;
      cfg_r.lost_timeout_ms    <= LOST_TIMEOUT_RST;
      cfg_r.deadband_q4        <= DEADBAND_RST;
      cfg_r.deg_per_step       <= DEG_PER_STEP_RST;
      cfg_r.reacquire_grace_ms <= GRACE_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_STEP_LIMIT:   cfg_r.step_limit         <= cfg_pwdata[6:0];
        REG_LOST_TIMEOUT: cfg_r.lost_timeout_ms    <= cfg_pwdata[15:0];
        REG_DEADBAND:     cfg_r.deadband_q4        <= cfg_pwdata[9:0];
        REG_DEG_PER_STEP: cfg_r.deg_per_step       <= cfg_pwdata[7:0];
        REG_GRACE:        cfg_r.reacquire_grace_ms <= cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_STEP_LIMIT:   cfg_prdata = {25'd0, cfg_r.step_limit};
      REG_LOST_TIMEOUT: cfg_prdata = {16'd0, cfg_r.lost_timeout_ms};
      REG_DEADBAND:     cfg_prdata = {22'd0, cfg_r.deadband_q4};
      REG_DEG_PER_STEP: cfg_prdata = {24'd0, cfg_r.deg_per_step};
      REG_GRACE:        cfg_prdata = {16'd0, cfg_r.reacquire_grace_ms};
      default:          cfg_prdata = 32'd0;
    endcase
  end

endmodule

// ----- verif/camera_pan_track_search_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// camera_pan_track_search_test: self-checking bench for the pan tracker
// Drives frame, block, motor tick and unknown items through the input
// channel while the result channel stalls at random. Every accepted item is
// run through a local model of the tracker. Each result transfer is compared
// field by field with the oldest outstanding expectation. The run walks a
// directed table at reset values, then random traffic under several
// register settings, extremes included.
// ----------------------------------------------------------------------------
module camera_pan_track_search_test;
  import cpts_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int ANGLE_GAIN = 1200;
  localparam int ANGLE_BIAS = 191400;
  localparam int IMG_SPAN_PX = 319;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_SETTINGS = 7;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  in_item_t   in_data = '0;
  logic       sink_ready = 1'b0;
  int         sink_hold = 0;

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cpts_in_if  in_ch ();
  cpts_out_if out_ch ();

  assign in_ch.valid     = in_valid;
  assign in_ch.cmd       = in_data.cmd;
  assign in_ch.time_ms   = in_data.time_ms;
  assign in_ch.target    = in_data.target;
  assign in_ch.signature = in_data.signature;
  assign in_ch.block_x   = in_data.block_x;
  assign in_ch.block_y   = in_data.block_y;
  assign out_ch.ready    = sink_ready;

  camera_pan_track_search DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Tracker model state.
  cfg_t        cfg_model;
  logic [15:0] cur_target;
  int          ball_angle;
  logic [7:0]  ball_row;
  bit          ball_found;
  bit          searching;
  bit          sweep_fwd;
  int          pan_pos;
  logic [31:0] last_seen;

  out_item_t   pending_pan_reports[$];
  probe_row_t  directed_rows[$];

  logic [31:0] clock_ms = '0;
  int          hunt_left = 0;
  bit          steady = 1'b0;
  int          quiet_cycles = 0;
  int          fault_count = 0;
  int          items_sent = 0;
  int          reports_seen = 0;
  int          steps_fwd = 0;
  int          steps_bwd = 0;
  int          settings_used = 0;

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [1:0] pan_step(bit forward);
    if (forward) begin
      pan_pos = clampi(pan_pos + 1, -128, 127);
      steps_fwd++;
      return STEP_FWD;
    end
    pan_pos = clampi(pan_pos - 1, -128, 127);
    steps_bwd++;
    return STEP_BWD;
  endfunction

  // Lost ball: reverse at or beyond the limits, otherwise step toward the last
  // angle until a sweep has started.
  function automatic logic [1:0] sweep_step();
    int l1;
    l1 = int'(cfg_model.step_limit) - 1;
    if (pan_pos > l1) begin
      searching = 1'b1;
      sweep_fwd = 1'b0;
    end else if (pan_pos < -l1) begin
      searching = 1'b1;
      sweep_fwd = 1'b1;
    end else if (!searching) begin
      return pan_step(ball_angle <= 0);
    end
    return pan_step(sweep_fwd);
  endfunction

  function automatic out_item_t predict_pan_report(in_item_t it);
    out_item_t   r;
    logic [31:0] elapsed;
    int          lim;
    int          bearing;
    lim = int'(cfg_model.step_limit);
    r.step = STEP_NONE;
    case (it.cmd)
      CMD_FRAME: begin
        if (it.target != cur_target) begin
          cur_target = it.target;
          last_seen = it.time_ms + cfg_model.reacquire_grace_ms;
        end
        pan_pos = clampi(pan_pos, -lim, lim);
      end
      CMD_BLOCK: begin
        if (it.signature == cur_target) begin
          ball_angle = clampi((ANGLE_GAIN * int'(it.block_x) - ANGLE_BIAS) / IMG_SPAN_PX,
                              -1024, 1023);
          ball_row = it.block_y;
          ball_found = 1'b1;
          last_seen = it.time_ms;
        end
      end
      CMD_TICK: begin
        elapsed = it.time_ms - last_seen;
        if (elapsed > cfg_model.lost_timeout_ms) begin
          r.step = sweep_step();
        end else if (ball_found && !(magnitude(pan_pos) > lim - 1)) begin
          sweep_fwd = 1'b1;
          searching = 1'b0;
          if (magnitude(ball_angle) >= int'(cfg_model.deadband_q4))
            r.step = pan_step(ball_angle <= 0);
          ball_found = 1'b0;
        end
      end
      default: begin
      end
    endcase
    elapsed = it.time_ms - last_seen;
    bearing = clampi(-ball_angle + pan_pos * int'(cfg_model.deg_per_step) * 16,
                     -32768, 32767);
    r.pan_position = 8'(pan_pos);
    r.bearing_q4 = 16'(bearing);
    r.ball_row = ball_row;
    r.visible = (elapsed < cfg_model.lost_timeout_ms);
    return r;
  endfunction

  function automatic void add_row(logic [1:0] cmd, logic [31:0] t, logic [15:0] tgt,
                                  logic [15:0] sig, logic [8:0] x, logic [7:0] y,
                                  bit typed, logic [1:0] st, int pos, int bearing,
                                  int row, bit vis);
    probe_row_t p;
    p.stim = '{cmd: cmd, time_ms: t, target: tgt, signature: sig, block_x: x, block_y: y};
    p.typed = typed;
    p.want = '{step: st, pan_position: 8'(pos), bearing_q4: 16'(bearing),
               ball_row: 8'(row), visible: vis};
    directed_rows.push_back(p);
  endfunction

  // Random traffic is mostly frames, matching blocks and ticks on a slowly
  // advancing clock. Now and then a target change starts a run of ticks so
  // the sweep reaches the limits.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it.cmd = CMD_UNKNOWN;
    it.target = 16'($urandom);
    it.signature = 16'($urandom);
    it.block_x = 9'($urandom);
    it.block_y = 8'($urandom);
    pick = $urandom_range(99);
    if (hunt_left > 0) begin
      hunt_left--;
      it.cmd = CMD_TICK;
    end else if (pick < 2) begin
      hunt_left = $urandom_range(10, 2 * int'(cfg_model.step_limit) + 12);
      it.cmd = CMD_FRAME;
      it.target = cur_target ^ 16'($urandom_range(1, 16'hFFFF));
    end else if (pick < 14) begin
      it.cmd = CMD_FRAME;
      pick = $urandom_range(99);
      if (pick < 75) it.target = cur_target;
      else if (pick < 85) it.target = pick[0] ? 16'hFFFF : 16'h0000;
    end else if (pick < 50) begin
      it.cmd = CMD_BLOCK;
      if ($urandom_range(99) < 80) it.signature = cur_target;
      it.block_x = ($urandom_range(99) < 85) ? 9'($urandom_range(0, 319))
                                              : 9'($urandom_range(320, 511));
      it.block_y = ($urandom_range(99) < 90) ? 8'($urandom_range(0, 199))
                                              : 8'($urandom_range(200, 255));
    end else if (pick < 97) begin
      it.cmd = CMD_TICK;
    end
    pick = $urandom_range(99);
    if (hunt_left > 0 || pick < 55)
      clock_ms += $urandom_range(0, 8);
    else if (pick < 85)
      clock_ms += $urandom_range(0, 2 * int'(cfg_model.lost_timeout_ms) + 4);
    else if (pick < 97)
      clock_ms += $urandom_range(0, 3000);
    else
      clock_ms = $urandom;
    if (it.cmd == CMD_TICK && $urandom_range(99) < 8)
      clock_ms = last_seen + cfg_model.lost_timeout_ms + $urandom_range(0, 2) - 1;
    it.time_ms = clock_ms;
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int        gap;
    out_item_t predicted;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_pan_report(it);
    pending_pan_reports.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Leaves psel high between back-to-back writes.
  task automatic write_reg(logic [2:0] index, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {index, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (index)
      REG_STEP_LIMIT:   cfg_model.step_limit = value[6:0];
      REG_LOST_TIMEOUT: cfg_model.lost_timeout_ms = value[15:0];
      REG_DEADBAND:     cfg_model.deadband_q4 = value[9:0];
      REG_DEG_PER_STEP: cfg_model.deg_per_step = value[7:0];
      REG_GRACE:        cfg_model.reacquire_grace_ms = value[15:0];
      default: begin
      end
    endcase
  endtask

  task automatic log_fault(string what, out_item_t want, out_item_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t: %s: expected step=%0d pos=%0d bearing=%0d row=%0d vis=%0b,",
               $time, what, want.step, want.pan_position, want.bearing_q4,
               want.ball_row, want.visible,
               " got step=%0d pos=%0d bearing=%0d row=%0d vis=%0b",
               got.step, got.pan_position, got.bearing_q4, got.ball_row, got.visible);
  endtask

  task automatic check_report(out_item_t got);
    out_item_t want;
    reports_seen++;
    if (pending_pan_reports.size() == 0) begin
      log_fault("result with nothing outstanding", '0, got);
    end else begin
      want = pending_pan_reports.pop_front();
      if (got.step !== want.step || got.pan_position !== want.pan_position ||
          got.bearing_q4 !== want.bearing_q4 || got.ball_row !== want.ball_row ||
          got.visible !== want.visible)
        log_fault("result mismatch", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      check_report({out_ch.step, out_ch.pan_position, out_ch.bearing_q4,
                    out_ch.ball_row, out_ch.visible});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (sink_hold > 0) begin
      sink_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (!steady && $urandom_range(99) < 15) begin
      sink_ready <= 1'b0;
      sink_hold <= idle_len();
    end else begin
      sink_ready <= 1'b1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_pan_reports.size());
    $display("** camera_pan_track_search: FAILED **");
    $finish;
  end

  initial begin
    cfg_t settings[NUM_SETTINGS];
    int   phase_items[NUM_SETTINGS];
    cfg_model = '{step_limit: STEP_LIMIT_RST, lost_timeout_ms: LOST_TIMEOUT_RST,
                  deadband_q4: DEADBAND_RST, deg_per_step: DEG_PER_STEP_RST,
                  reacquire_grace_ms: GRACE_RST};
    cur_target = '0;
    ball_angle = 0;
    ball_row = '0;
    ball_found = 1'b0;
    searching = 1'b0;
    sweep_fwd = 1'b1;
    pan_pos = 0;
    last_seen = '0;

    //       cmd          time          target    sig       x       y     typed step
    add_row(CMD_TICK,    32'd0,        16'h0000, 16'h0000, 9'd0,   8'd0,   1, STEP_NONE,
            0, 0, 0, 1);
    add_row(CMD_UNKNOWN, 32'd10,       16'hFFFF, 16'hFFFF, 9'd511, 8'd255, 1, STEP_NONE,
            0, 0, 0, 1);
    add_row(CMD_BLOCK,   32'd20,       16'hFFFF, 16'h0000, 9'd0,   8'd0,   1, STEP_NONE,
            0, 600, 0, 1);
    add_row(CMD_TICK,    32'd30,       16'h0000, 16'h0000, 9'd0,   8'd0,   1, STEP_FWD,
            1, 728, 0, 1);
    add_row(CMD_BLOCK,   32'd40,       16'h0000, 16'h0000, 9'd319, 8'd199, 1, STEP_NONE,
            1, -472, 199, 1);
    add_row(CMD_TICK,    32'd90,       16'h0000, 16'h0000, 9'd0,   8'd0,   1, STEP_BWD,
            0, -600, 199, 0);
    add_row(CMD_BLOCK,   32'd100,      16'h0000, 16'h0000, 9'd511, 8'd255, 1, STEP_NONE,
            0, -1023, 255, 1);
    add_row(CMD_BLOCK,   32'd105,      16'h0000, 16'hFFFF, 9'd160, 8'd100, 1, STEP_NONE,
            0, -1023, 255, 1);
    add_row(CMD_FRAME,   32'd110,      16'hFFFF, 16'h0000, 9'd0,   8'd0,   1, STEP_NONE,
            0, -1023, 255, 0);
    add_row(CMD_TICK,    32'd120,      16'h0000, 16'h0000, 9'd0,   8'd0,   1, STEP_BWD,
            -1, -1151, 255, 0);
    add_row(CMD_BLOCK,   32'd1200,     16'h0000, 16'hFFFF, 9'd160, 8'd77,  0, STEP_NONE,
            0, 0, 0, 0);
    add_row(CMD_TICK,    32'd1210,     16'h0000, 16'h0000, 9'd0,   8'd0,   0, STEP_NONE,
            0, 0, 0, 0);
    add_row(CMD_TICK,    32'd1261,     16'h0000, 16'h0000, 9'd0,   8'd0,   0, STEP_NONE,
            0, 0, 0, 0);
    add_row(CMD_BLOCK,   32'd1262,     16'h0000, 16'hFFFF, 9'd321, 8'd200, 0, STEP_NONE,
            0, 0, 0, 0);
    add_row(CMD_FRAME,   32'hFFFFFFF0, 16'h8001, 16'h0000, 9'd0,   8'd0,   0, STEP_NONE,
            0, 0, 0, 0);
    add_row(CMD_TICK,    32'hFFFFFFF8, 16'h0000, 16'h0000, 9'd0,   8'd0,   0, STEP_NONE,
            0, 0, 0, 0);
    add_row(CMD_BLOCK,   32'h00000004, 16'h0000, 16'h8001, 9'd0,   8'd1,   0, STEP_NONE,
            0, 0, 0, 0);
    add_row(CMD_TICK,    32'h00000030, 16'h0000, 16'h0000, 9'd0,   8'd0,   0, STEP_NONE,
            0, 0, 0, 0);
    add_row(CMD_UNKNOWN, 32'h7FFFFFFF, 16'h0000, 16'h0000, 9'd0,   8'd0,   0, STEP_NONE,
            0, 0, 0, 0);

    settings[0] = cfg_model;
    settings[1] = '{step_limit: 7'd127, lost_timeout_ms: 16'hFFFF, deadband_q4: 10'h3FF,
                    deg_per_step: 8'hFF, reacquire_grace_ms: 16'hFFFF};
    settings[2] = '{step_limit: 7'd2, lost_timeout_ms: 16'd0, deadband_q4: 10'd0,
                    deg_per_step: 8'd0, reacquire_grace_ms: 16'd0};
    settings[3] = '{step_limit: 7'd0, lost_timeout_ms: 16'd30, deadband_q4: 10'd100,
                    deg_per_step: 8'd3, reacquire_grace_ms: 16'd10};
    settings[4] = '{step_limit: 7'd1, lost_timeout_ms: 16'd60, deadband_q4: 10'd300,
                    deg_per_step: 8'd20, reacquire_grace_ms: 16'd2000};
    settings[5] = '{step_limit: 7'd64, lost_timeout_ms: 16'd200, deadband_q4: 10'd512,
                    deg_per_step: 8'd128, reacquire_grace_ms: 16'd40000};
    settings[6] = '{step_limit: 7'($urandom_range(2, 127)),
                    lost_timeout_ms: 16'($urandom_range(0, 300)),
                    deadband_q4: 10'($urandom_range(0, 1023)),
                    deg_per_step: 8'($urandom_range(0, 255)),
                    reacquire_grace_ms: 16'($urandom)};
    phase_items = '{200, 200, 120, 80, 80, 150, 200};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    clock_ms = directed_rows[directed_rows.size() - 1].stim.time_ms;

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      // Registers change only with the pipeline drained.
      in_valid <= 1'b0;
      while (pending_pan_reports.size() != 0) @(posedge clk);
      write_reg(REG_STEP_LIMIT, 32'(settings[p].step_limit));
      write_reg(REG_LOST_TIMEOUT, 32'(settings[p].lost_timeout_ms));
      write_reg(REG_DEADBAND, 32'(settings[p].deadband_q4));
      write_reg(REG_DEG_PER_STEP, 32'(settings[p].deg_per_step));
      write_reg(REG_GRACE, 32'(settings[p].reacquire_grace_ms));
      cfg_psel <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite <= 1'b0;
      settings_used++;
      steady = (p == 3);
      hunt_left = 0;
      for (int n = 0; n < phase_items[p]; n++)
        send_item(random_item(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_pan_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d input transfers and %0d result transfers over %0d settings.",
             items_sent, reports_seen, settings_used);
    $display("Predicted motor steps: %0d forward, %0d backward; %0d mismatches.",
             steps_fwd, steps_bwd, fault_count);
    if (fault_count == 0)
      $display("** camera_pan_track_search: PASSED **");
    else
      $display("** camera_pan_track_search: FAILED **");
    $finish;
  end

endmodule
